FILE: src/minmax_calibrated_normalizer_core_defines.svh
// Assertion macros shared by the checker of the calibrated normalizer.
// Included by bare file name; no other dependencies.
`ifndef MINMAX_CALIBRATED_NORMALIZER_CORE_DEFINES_SVH
`define MINMAX_CALIBRATED_NORMALIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MCN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/mcn_pkg.sv
// Shared types and constants of the calibrated min/max normalizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package mcn_pkg;

    // Default configuration of the block.
    localparam int CHANNELS_DEF    = 7;
    localparam int SAMPLE_BITS_DEF = 12;

    // Field widths of the stream payloads.
    localparam int MODE_W    = 1;
    localparam int CH_W      = 3;
    localparam int SAMPLE_W  = 12;
    localparam int LEVEL_W   = 8;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int M_PAD_W   = M_TDATA_W - CH_W - LEVEL_W;

    // Quotient bits produced by the divider, one per step.
    localparam int QUOT_W = LEVEL_W;
    localparam int STEP_W = $clog2(QUOT_W);

    // Saturated output codes.
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'h7F;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'h80;

    // Item modes carried in tuser.
    localparam logic [MODE_W-1:0] MODE_CAL  = 1'b0;
    localparam logic [MODE_W-1:0] MODE_NORM = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_PREP  = 5'b00100,
        S_DIV   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic start;
        logic neg;
    } t_div_req;

endpackage

`default_nettype wire

FILE: src/minmax_calibrated_normalizer_core.sv
// Normalize in range: the item passes FETCH, PREP, the divider steps in DIV, then FIN;
// the 8 divider steps produce one quotient bit per cycle.
// Normalize with empty span, below minimum or at/above maximum: FETCH then FIN, no division.
// Calibrate and out-of-range items: FETCH then back to idle, no result.
// Ready only in the idle state; a stalled output register holds the sequencer in FIN.
// Synchronous active-low reset: minimums to all ones, maximums to zero, idle.
`default_nettype none

module minmax_calibrated_normalizer_core
    import mcn_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Slave stream. tdata: channel [2:0], sample [14:3], zero [15].
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: mode [0].
    input  wire logic [MODE_W-1:0]    i_s_axis_tuser,
    // Master stream. tdata: channel_out [2:0], level [10:3], zero [15:11].
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic      [M_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DW    = SAMPLE_BITS + QUOT_W;
    localparam int NW    = SAMPLE_BITS + QUOT_W + 1;

    t_state                 r_state;
    t_state                 n_state;
    logic [MODE_W-1:0]      r_mode;
    logic [CH_W-1:0]        r_ch;
    logic [SAMPLE_BITS-1:0] r_x;
    logic [SAMPLE_BITS-1:0] r_span;
    logic [SAMPLE_BITS-1:0] r_d;
    logic [LEVEL_W-1:0]     r_level;
    logic                   r_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data;

    logic                   w_in_xfer;
    logic                   w_ch_ok;
    logic                   w_cal_wr;
    logic                   w_out_load;
    logic [IDX_W-1:0]       w_idx;
    logic [SAMPLE_BITS-1:0] w_lo;
    logic [SAMPLE_BITS-1:0] w_hi;
    logic [NW-1:0]          w_num;
    logic [NW-1:0]          w_abs;
    t_div_req               w_req;
    logic                   w_div_done;
    logic [LEVEL_W-1:0]     w_div_level;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ch_ok         = (int'(r_ch) < CHANNELS);
    assign w_idx           = IDX_W'(r_ch);
    assign w_cal_wr        = (r_state == S_FETCH) && w_ch_ok && (r_mode == MODE_CAL);
    assign w_out_load      = (r_state == S_FIN) && (!r_out_valid || i_m_axis_tready);

    // Calibration bounds of every channel.
    mcn_cal #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (w_cal_wr),
        .i_idx   (w_idx),
        .i_x     (r_x),
        .o_lo    (w_lo),
        .o_hi    (w_hi)
    );

    // Numerator 255*d - 128*span, then its sign and magnitude.
    assign w_num = {1'b0, r_d, 8'b0} - NW'(r_d) - {2'b0, r_span, 7'b0};
    assign w_abs = w_num[NW-1] ? (~w_num + NW'(1)) : w_num;

    assign w_req.start = (r_state == S_PREP);
    assign w_req.neg   = w_num[NW-1];

    // Shared iterative divider.
    mcn_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_mag   (w_abs[DW-1:0]),
        .i_span  (r_span),
        .o_done  (w_div_done),
        .o_level (w_div_level)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (!w_ch_ok || (r_mode == MODE_CAL)) begin
                    n_state = S_IDLE;
                end else if ((w_hi <= w_lo) || (r_x < w_lo) || (r_x >= w_hi)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers: state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: captured item, span, offset, level and output word.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_mode <= i_s_axis_tuser;
            r_ch   <= i_s_axis_tdata[CH_W-1:0];
            r_x    <= SAMPLE_BITS'(i_s_axis_tdata[CH_W +: SAMPLE_W]);
        end
        if (r_state == S_FETCH) begin
            r_span <= w_hi - w_lo;
            r_d    <= r_x - w_lo;
            // Empty span and samples below the minimum saturate low.
            if ((w_hi <= w_lo) || (r_x < w_lo)) begin
                r_level <= LEVEL_MIN;
            end else if (r_x >= w_hi) begin
                r_level <= LEVEL_MAX;
            end
        end
        if ((r_state == S_DIV) && w_div_done) begin
            r_level <= w_div_level;
        end
        if (w_out_load) begin
            r_out_data <= {{M_PAD_W{1'b0}}, r_level, r_ch};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

FILE: src/mcn_cal.sv
// Per-channel calibration store: minimum and maximum sample of each channel.
// Depends on mcn_pkg.
`default_nettype none

module mcn_cal
    import mcn_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_wr_en,
    input  wire logic [IDX_W-1:0]       i_idx,
    input  wire logic [SAMPLE_BITS-1:0] i_x,
    output logic      [SAMPLE_BITS-1:0] o_lo,
    output logic      [SAMPLE_BITS-1:0] o_hi
);

    logic [SAMPLE_BITS-1:0] r_min [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_max [CHANNELS];

    // Read the bounds of the selected channel.
    assign o_lo = r_min[i_idx];
    assign o_hi = r_max[i_idx];

    // A calibration sample widens the stored bounds of its channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_min[i] <= '1;
                r_max[i] <= '0;
            end
        end else if (i_wr_en) begin
            if (i_x >= r_max[i_idx]) begin
                r_max[i_idx] <= i_x;
            end
            if (i_x <= r_min[i_idx]) begin
                r_min[i_idx] <= i_x;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/mcn_div.sv
// Iterative restoring divider: one compare and subtract per cycle, one
// quotient bit per step, signed result by magnitude and sign. Depends on mcn_pkg.
`default_nettype none

module mcn_div
    import mcn_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int DW         = SAMPLE_BITS + QUOT_W
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_div_req               i_req,
    input  wire logic [DW-1:0]          i_mag,
    input  wire logic [SAMPLE_BITS-1:0] i_span,
    output logic                        o_done,
    output logic      [LEVEL_W-1:0]     o_level
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [QUOT_W-1:0] r_q;
    logic              r_neg;

    logic              w_fit;

    // The shared unit: one compare of the remainder against the shifted divisor.
    assign w_fit = (r_rem >= r_den);

    // Control: step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(QUOT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath: the divisor starts at its top quotient weight and shifts right.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_mag;
            r_den <= {1'b0, i_span, {(QUOT_W-1){1'b0}}};
            r_q   <= '0;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_den;
            end
            r_q   <= {r_q[QUOT_W-2:0], w_fit};
            r_den <= r_den >> 1;
        end
    end

    // Truncation toward zero: negate the magnitude quotient when needed.
    assign o_done  = r_done;
    assign o_level = r_neg ? LEVEL_W'(~r_q + 1'b1) : LEVEL_W'(r_q);

endmodule

`default_nettype wire

FILE: src/mcn_checker.sv
// Port-level checker of the calibrated normalizer and its bind to the top level.
// Depends on mcn_pkg and the assertion macros header.
`default_nettype none
`include "minmax_calibrated_normalizer_core_defines.svh"

module mcn_checker
    import mcn_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_s_axis_tvalid,
    input wire logic                 o_s_axis_tready,
    input wire logic                 o_m_axis_tvalid,
    input wire logic                 i_m_axis_tready,
    input wire logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    logic w_in_xfer;
    logic w_stall;

    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign w_stall   = o_m_axis_tvalid && !i_m_axis_tready;

    // A stalled result holds its data.
    `MCN_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, w_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // One item at a time: ready drops after every input transfer.
    `MCN_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, w_in_xfer, !o_s_axis_tready)
    // No result appears in the cycle right after an item enters an empty output.
    `MCN_ASSERT_NEXT(a_no_instant_out, i_clk, i_rst_n, w_in_xfer && !o_m_axis_tvalid, !o_m_axis_tvalid)
    // The padding above the level field is always zero.
    `MCN_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[M_TDATA_W-1:CH_W+LEVEL_W] == '0)

endmodule

bind minmax_calibrated_normalizer_core mcn_checker u_mcn_checker (.*);

`default_nettype wire

FILE: sim/tb_minmax_calibrated_normalizer_core.sv
// Self-checking testbench of the calibrated min/max normalizer core.
// Streams calibrate and normalize transfers and checks each output level against
// an in-bench model of the per-channel bounds; depends on mcn_pkg and the core.
`default_nettype none

module tb_minmax_calibrated_normalizer_core;
    import mcn_pkg::*;

    localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 400;
    localparam int MAX_WAIT    = 19;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [CH_W-1:0] CH_UNUSED = CH_W'(CHANNELS_DEF);

    // One row of the directed table; a pinned level is used when has_fix is set.
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] sample;
        logic                has_fix;
        logic [LEVEL_W-1:0]  level;
    } t_dir_row;

    // One expected normalize result.
    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic [LEVEL_W-1:0] level;
    } t_level_exp;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [MODE_W-1:0]    s_tuser = '0;
    logic                 m_tready = 1'b0;
    wire logic            s_tready;
    wire logic            m_tvalid;
    wire logic [M_TDATA_W-1:0] m_tdata;

    // Model of the calibrated bounds of every channel.
    logic [SAMPLE_W-1:0] bound_lo [CHANNELS_DEF];
    logic [SAMPLE_W-1:0] bound_hi [CHANNELS_DEF];
    t_level_exp          level_queue [$];
    int                  err_count = 0;

    // Per-channel sample windows of the random part.
    int win_base [CHANNELS_DEF];
    int win_size [CHANNELS_DEF];

    t_dir_row dir_rows [N_DIRECTED];
    bit       s_calm = 1'b0;
    bit       m_calm = 1'b0;

    minmax_calibrated_normalizer_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Maps a sample onto the signed 8-bit level using exact integer math.
    function automatic logic [LEVEL_W-1:0] norm_level(int x, int lo, int hi);
        int span;
        int num;
        if (hi <= lo || x < lo) begin
            return LEVEL_MIN;
        end
        if (x >= hi) begin
            return LEVEL_MAX;
        end
        span = hi - lo;
        num  = 255 * (x - lo) - 128 * span;
        // Signed division truncates toward zero, as required.
        return LEVEL_W'(num / span);
    endfunction

    // Applies one accepted input transfer to the bounds model and records the
    // expected result, if any.
    task automatic note_transfer(logic [MODE_W-1:0] mode, logic [CH_W-1:0] ch,
                                 logic [SAMPLE_W-1:0] smp, logic has_fix,
                                 logic [LEVEL_W-1:0] fix_level);
        t_level_exp exp_item;
        if (ch >= CHANNELS_DEF) begin
            return;
        end
        if (mode == MODE_CAL) begin
            if (smp >= bound_hi[ch]) begin
                bound_hi[ch] = smp;
            end
            if (smp <= bound_lo[ch]) begin
                bound_lo[ch] = smp;
            end
        end else begin
            exp_item.ch    = ch;
            exp_item.level = has_fix ? fix_level
                                     : norm_level(smp, bound_lo[ch], bound_hi[ch]);
            level_queue.push_back(exp_item);
        end
    endtask

    // Drives one item after a random gap and waits for its transfer.
    task automatic send_item(logic [MODE_W-1:0] mode, logic [CH_W-1:0] ch,
                             logic [SAMPLE_W-1:0] smp, logic has_fix,
                             logic [LEVEL_W-1:0] fix_level);
        int gap;
        if ($urandom_range(0, 29) == 0) begin
            s_calm = ~s_calm;
        end
        gap = s_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, smp, ch};
        s_tuser  <= mode;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        note_transfer(mode, ch, smp, has_fix, fix_level);
    endtask

    // Output side: random ready gaps, and a check of every output transfer.
    initial begin
        int         gap;
        t_level_exp exp_item;
        wait (i_rst_n);
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                m_calm = ~m_calm;
            end
            gap = m_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!m_tvalid);
            if (level_queue.size() == 0) begin
                $error("unexpected output transfer, tdata %h", m_tdata);
                err_count++;
            end else begin
                exp_item = level_queue.pop_front();
                if (m_tdata[CH_W-1:0] !== exp_item.ch) begin
                    $error("channel_out: expected %0d, actual %0d",
                           exp_item.ch, m_tdata[CH_W-1:0]);
                    err_count++;
                end
                if (m_tdata[CH_W +: LEVEL_W] !== exp_item.level) begin
                    $error("level: expected %0d, actual %0d",
                           $signed(exp_item.level), $signed(m_tdata[CH_W +: LEVEL_W]));
                    err_count++;
                end
            end
        end
    end

    // Reset, directed table, random stream, drain and verdict.
    initial begin
        int                  done;
        int                  lo_w;
        int                  hi_w;
        logic [MODE_W-1:0]   mode;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] smp;

        // Bounds after reset: empty range on every channel.
        for (int c = 0; c < CHANNELS_DEF; c++) begin
            bound_lo[c] = SAMPLE_W'(SAMPLE_MAX);
            bound_hi[c] = '0;
        end

        dir_rows = '{
            // Uncalibrated channels give the minimum level.
            '{MODE_NORM, 3'd0, 12'd0,    1'b1, LEVEL_MIN},
            '{MODE_NORM, 3'd6, 12'd4095, 1'b1, LEVEL_MIN},
            // Out-of-range channel is ignored in both modes.
            '{MODE_CAL,  CH_UNUSED, 12'd1234, 1'b0, 8'd0},
            '{MODE_NORM, CH_UNUSED, 12'd4095, 1'b0, 8'd0},
            // Full-scale calibration.
            '{MODE_CAL,  3'd1, 12'd0,    1'b0, 8'd0},
            '{MODE_CAL,  3'd1, 12'd4095, 1'b0, 8'd0},
            '{MODE_NORM, 3'd1, 12'd4095, 1'b1, LEVEL_MAX},
            '{MODE_NORM, 3'd1, 12'd0,    1'b1, LEVEL_MIN},
            '{MODE_NORM, 3'd1, 12'd2048, 1'b0, 8'd0},
            '{MODE_NORM, 3'd1, 12'd2047, 1'b0, 8'd0},
            // Single-point calibration leaves a zero span.
            '{MODE_CAL,  3'd3, 12'd500,  1'b0, 8'd0},
            '{MODE_NORM, 3'd3, 12'd500,  1'b1, LEVEL_MIN},
            // Narrow range: below, above, at the upper bound and just inside both bounds.
            '{MODE_CAL,  3'd2, 12'd200,  1'b0, 8'd0},
            '{MODE_CAL,  3'd2, 12'd100,  1'b0, 8'd0},
            '{MODE_NORM, 3'd2, 12'd50,   1'b1, LEVEL_MIN},
            '{MODE_NORM, 3'd2, 12'd250,  1'b1, LEVEL_MAX},
            '{MODE_NORM, 3'd2, 12'd200,  1'b1, LEVEL_MAX},
            '{MODE_NORM, 3'd2, 12'd101,  1'b0, 8'd0},
            '{MODE_NORM, 3'd2, 12'd199,  1'b0, 8'd0},
            // Alternating bit patterns as bounds.
            '{MODE_CAL,  3'd5, 12'hAAA,  1'b0, 8'd0},
            '{MODE_CAL,  3'd5, 12'h555,  1'b0, 8'd0},
            '{MODE_NORM, 3'd5, 12'd2000, 1'b0, 8'd0},
            // Span of one at the top of the range.
            '{MODE_CAL,  3'd4, 12'd4095, 1'b0, 8'd0},
            '{MODE_CAL,  3'd4, 12'd4094, 1'b0, 8'd0},
            '{MODE_NORM, 3'd4, 12'd4094, 1'b1, LEVEL_MIN}
        };

        // Windows from a few codes wide up to the full scale.
        win_size = '{2, 17, 130, 700, 1900, 4095, 40};
        for (int c = 0; c < CHANNELS_DEF; c++) begin
            win_base[c] = $urandom_range(0, SAMPLE_MAX - win_size[c]);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_item(dir_rows[r].mode, dir_rows[r].ch, dir_rows[r].sample,
                      dir_rows[r].has_fix, dir_rows[r].level);
        end

        // Random stream; ignored channel items do not count.
        done = 0;
        while (done < N_RANDOM) begin
            if ($urandom_range(0, 99) < 5) begin
                mode = MODE_W'($urandom_range(0, 1));
                ch   = CH_UNUSED;
                smp  = SAMPLE_W'($urandom);
            end else begin
                ch = CH_W'($urandom_range(0, CHANNELS_DEF - 1));
                if ($urandom_range(0, 99) < 40) begin
                    mode = MODE_CAL;
                    smp  = SAMPLE_W'(win_base[ch] + $urandom_range(0, win_size[ch]));
                end else begin
                    mode = MODE_NORM;
                    if ($urandom_range(0, 99) < 15) begin
                        smp = SAMPLE_W'($urandom);
                    end else begin
                        // Stretch the window a little to reach both clamps.
                        lo_w = win_base[ch] - win_size[ch] / 4 - 1;
                        hi_w = win_base[ch] + win_size[ch] + win_size[ch] / 4 + 1;
                        if (lo_w < 0) begin
                            lo_w = 0;
                        end
                        if (hi_w > SAMPLE_MAX) begin
                            hi_w = SAMPLE_MAX;
                        end
                        smp = SAMPLE_W'($urandom_range(lo_w, hi_w));
                    end
                end
                done++;
            end
            send_item(mode, ch, smp, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then watch for stray output.
        while (level_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+src
src/mcn_pkg.sv
src/mcn_cal.sv
src/mcn_div.sv
src/minmax_calibrated_normalizer_core.sv
src/mcn_checker.sv
sim/tb_minmax_calibrated_normalizer_core.sv
